>>> hw/rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// Page frame allocator package
// Request and response types, request modes, status codes and controller
// states that the allocator modules share.
// ----------------------------------------------------------------------------
package pfa_pkg;

   // Width of the page number fields on the ports.
   localparam int PAGE_NUM_W = 13;
   // Width of the free page counter.
   localparam int FREE_CNT_W = 14;
   // Width of the kernel free page counter.
   localparam int KFREE_CNT_W = 11;
   // Bits in one word of the in-use bitmap.
   localparam int MAP_WORD_W = 32;
   // Bits that select a page inside one bitmap word.
   localparam int MAP_BIT_W = 5;

   // Request modes.
   typedef enum logic [1:0] {
      MODE_RELEASE      = 2'd0,
      MODE_ALLOC_USER   = 2'd1,
      MODE_ALLOC_KERNEL = 2'd2,
      MODE_MARK         = 2'd3
   } pfa_mode_type;

   // Response status codes.
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_NO_FREE = 1'b1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RMW,
      ST_SCAN,
      ST_DONE
   } pfa_state_type;

   // One request.
   typedef struct packed {
      pfa_mode_type            mode;
      logic [PAGE_NUM_W-1:0]   page_number;
   } pfa_req_type;

   // One response.
   typedef struct packed {
      logic [PAGE_NUM_W-1:0]   granted_page;
      logic                    status;
      logic [FREE_CNT_W-1:0]   free_total;
      logic [KFREE_CNT_W-1:0]  kernel_free_total;
   } pfa_rsp_type;

endpackage

>>> hw/rtl/pfa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// Page bitmap memory
// Single write port, single read port memory of bitmap words with a
// registered read output.
// ----------------------------------------------------------------------------
module pfa_bitmap_ram
   import pfa_pkg::*;
#(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [MAP_WORD_W-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [MAP_WORD_W-1:0] rd_data
);

   logic [MAP_WORD_W-1:0] mem [DEPTH];
   logic [MAP_WORD_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with a registered output.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/pfa_find_clear.sv
// ----------------------------------------------------------------------------
// Lowest clear bit finder
// Priority encoder that returns the position of the lowest zero bit of one
// bitmap word and whether there is one.
// ----------------------------------------------------------------------------
module pfa_find_clear
   import pfa_pkg::*;
(
   input  logic [MAP_WORD_W-1:0] word_in,
   output logic                  found,
   output logic [MAP_BIT_W-1:0]  index
);

   // Scan from the top so that the lowest clear bit wins.
   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
         if (!word_in[i]) begin
            found = 1'b1;
            index = MAP_BIT_W'(i);
         end
      end
   end

endmodule

>>> hw/rtl/page_frame_allocator.sv
// ----------------------------------------------------------------------------
// Page frame allocator
// First-fit physical page allocator with one in-use bit per page, a kernel
// pool below KERNEL_PAGE_COUNT and a user pool above it.
// ----------------------------------------------------------------------------
// Usage: a request carries a mode (release, allocate user, allocate kernel,
// mark in use) and a page number. Each request gives exactly one response
// with the granted page, a status and both free counters after the request.
// Both channels use valid/stall; a request is taken when req_valid is high
// and req_stall is low, a response leaves when rsp_valid is high and
// rsp_stall is low.
// Sequence: a release or mark reads the page's word, writes it back with the
// bit changed and then answers; an allocation searches its pool from the low
// end, one 32-bit word per cycle from the bitmap memory read port (the default
// map has 256 words), until it finds a clear bit or reaches the pool's last word.
// A request that is refused at once (no free pages, page beyond the map)
// skips the bitmap and answers directly. One request is handled at a time.
// Reset: the bitmap is cleared by a pass that writes one word per cycle
// over every word of the map, while req_stall stays high.
// Both counters start at zero.
// Stall: the response waits in its output register while rsp_stall is high;
// the next request is still accepted and its result is held until the
// output register is free.
// ----------------------------------------------------------------------------
module page_frame_allocator
   import pfa_pkg::*;
#(
   parameter int MAX_PAGE_COUNT    = 8192,
   parameter int KERNEL_PAGE_COUNT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pfa_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pfa_rsp_type rsp_data
);

   localparam int MAP_WORDS = (MAX_PAGE_COUNT + MAP_WORD_W - 1) / MAP_WORD_W;
   localparam int WORD_W    = $clog2(MAP_WORDS);
   localparam int PAGE_W    = $clog2(MAX_PAGE_COUNT);
   localparam int CMP_W     = ((PAGE_W > PAGE_NUM_W) ? PAGE_W : PAGE_NUM_W) + 1;
   localparam int KEND      = (KERNEL_PAGE_COUNT < MAX_PAGE_COUNT) ?
                              KERNEL_PAGE_COUNT : MAX_PAGE_COUNT;
   localparam bit USER_EMPTY = (KEND >= MAX_PAGE_COUNT);

   localparam logic [CMP_W-1:0] MAX_C  = CMP_W'(MAX_PAGE_COUNT);
   localparam logic [CMP_W-1:0] KEND_C = CMP_W'(KEND);

   localparam logic [FREE_CNT_W-1:0] FREE_LIMIT =
      FREE_CNT_W'((MAX_PAGE_COUNT < 16383) ? MAX_PAGE_COUNT : 16383);
   localparam logic [KFREE_CNT_W-1:0] KFREE_LIMIT =
      KFREE_CNT_W'((KERNEL_PAGE_COUNT < 2047) ? KERNEL_PAGE_COUNT : 2047);

   // Pool bounds as word index and bit position.
   localparam logic [WORD_W-1:0]    K_LO_WORD = '0;
   localparam logic [MAP_BIT_W-1:0] K_LO_BIT  = '0;
   localparam logic [WORD_W-1:0]    K_HI_WORD = WORD_W'((KEND - 1) / MAP_WORD_W);
   localparam logic [MAP_BIT_W-1:0] K_HI_BIT  = MAP_BIT_W'((KEND - 1) % MAP_WORD_W);
   localparam logic [WORD_W-1:0]    U_LO_WORD = WORD_W'(KEND / MAP_WORD_W);
   localparam logic [MAP_BIT_W-1:0] U_LO_BIT  = MAP_BIT_W'(KEND % MAP_WORD_W);
   localparam logic [WORD_W-1:0]    U_HI_WORD =
      WORD_W'((MAX_PAGE_COUNT - 1) / MAP_WORD_W);
   localparam logic [MAP_BIT_W-1:0] U_HI_BIT  =
      MAP_BIT_W'((MAX_PAGE_COUNT - 1) % MAP_WORD_W);
   localparam logic [WORD_W-1:0]    LAST_WORD = WORD_W'(MAP_WORDS - 1);

   pfa_state_type state_ff, state_in;

   pfa_mode_type          mode_ff, mode_in;
   logic [WORD_W-1:0]     page_word_ff, page_word_in;
   logic [MAP_BIT_W-1:0]  page_bit_ff, page_bit_in;
   logic                  kern_page_ff, kern_page_in;
   logic [WORD_W-1:0]     cur_ff, cur_in;
   logic [WORD_W-1:0]     clr_ff, clr_in;
   logic [PAGE_NUM_W-1:0] granted_ff, granted_in;
   logic                  status_ff, status_in;
   logic [FREE_CNT_W-1:0]  free_count_ff, free_count_in;
   logic [KFREE_CNT_W-1:0] kfree_ff, kfree_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   pfa_rsp_type           rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  load_rsp;
   logic [CMP_W-1:0]      page_ext;
   logic                  page_ok;
   logic                  alloc_fail_now;
   logic                  scan_kernel;
   logic [WORD_W-1:0]     lo_word, hi_word;
   logic [MAP_BIT_W-1:0]  lo_bit, hi_bit;
   logic [MAP_WORD_W-1:0] scan_word;
   logic                  hit;
   logic [MAP_BIT_W-1:0]  hit_bit;
   logic [WORD_W+MAP_BIT_W-1:0] hit_page;

   logic                  wr_en, rd_en;
   logic [WORD_W-1:0]     wr_addr, rd_addr;
   logic [MAP_WORD_W-1:0] wr_data, rd_data;

   pfa_bitmap_ram #(
      .DEPTH  (MAP_WORDS),
      .ADDR_W (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pfa_find_clear u_find (
      .word_in (scan_word),
      .found   (hit),
      .index   (hit_bit)
   );

   // Handshakes.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Request decode.
   assign page_ext = CMP_W'(req_data.page_number);
   assign page_ok  = (page_ext < MAX_C);
   assign alloc_fail_now = (free_count_ff == '0) ||
                           ((req_data.mode == MODE_ALLOC_USER) && USER_EMPTY);

   // Pool bounds of the search under way.
   assign scan_kernel = (mode_ff == MODE_ALLOC_KERNEL);
   assign lo_word = scan_kernel ? K_LO_WORD : U_LO_WORD;
   assign lo_bit  = scan_kernel ? K_LO_BIT  : U_LO_BIT;
   assign hi_word = scan_kernel ? K_HI_WORD : U_HI_WORD;
   assign hi_bit  = scan_kernel ? K_HI_BIT  : U_HI_BIT;

   // Pages outside the pool look as if in use.
   always_comb begin
      for (int i = 0; i < MAP_WORD_W; i++) begin
         scan_word[i] = rd_data[i] ||
                        ((cur_ff == lo_word) && (MAP_BIT_W'(i) < lo_bit)) ||
                        ((cur_ff == hi_word) && (MAP_BIT_W'(i) > hi_bit));
      end
   end

   assign hit_page = {cur_ff, hit_bit};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  MODE_RELEASE, MODE_MARK: begin
                     state_in = page_ok ? ST_RMW : ST_DONE;
                  end
                  default: begin
                     state_in = alloc_fail_now ? ST_DONE : ST_SCAN;
                  end
               endcase
            end
         end
         ST_RMW: begin
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (hit || (cur_ff == hi_word)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      mode_in       = mode_ff;
      page_word_in  = page_word_ff;
      page_bit_in   = page_bit_ff;
      kern_page_in  = kern_page_ff;
      cur_in        = cur_ff;
      clr_in        = clr_ff;
      granted_in    = granted_ff;
      status_in     = status_ff;
      free_count_in = free_count_ff;
      kfree_in      = kfree_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = cur_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               mode_in      = req_data.mode;
               page_word_in = WORD_W'(page_ext >> MAP_BIT_W);
               page_bit_in  = req_data.page_number[MAP_BIT_W-1:0];
               kern_page_in = (page_ext < KEND_C);
               granted_in   = '0;
               status_in    = STATUS_OK;
               case (req_data.mode)
                  MODE_RELEASE, MODE_MARK: begin
                     rd_en   = page_ok;
                     rd_addr = WORD_W'(page_ext >> MAP_BIT_W);
                  end
                  default: begin
                     cur_in  = (req_data.mode == MODE_ALLOC_KERNEL) ?
                               K_LO_WORD : U_LO_WORD;
                     rd_en   = !alloc_fail_now;
                     rd_addr = cur_in;
                     if (alloc_fail_now) begin
                        status_in = STATUS_NO_FREE;
                     end
                  end
               endcase
            end
         end
         ST_RMW: begin
            // Read-modify-write of one page bit.
            wr_en   = 1'b1;
            wr_addr = page_word_ff;
            wr_data = rd_data;
            if (mode_ff == MODE_MARK) begin
               wr_data[page_bit_ff] = 1'b1;
            end else begin
               wr_data[page_bit_ff] = 1'b0;
               if (free_count_ff < FREE_LIMIT) begin
                  free_count_in = free_count_ff + 1'b1;
               end
               if (kern_page_ff && (kfree_ff < KFREE_LIMIT)) begin
                  kfree_in = kfree_ff + 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               // Claim the page and count it out.
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = rd_data;
               wr_data[hit_bit] = 1'b1;
               granted_in    = PAGE_NUM_W'(hit_page);
               free_count_in = free_count_ff - 1'b1;
               if (scan_kernel && (kfree_ff != '0)) begin
                  kfree_in = kfree_ff - 1'b1;
               end
            end else if (cur_ff == hi_word) begin
               status_in = STATUS_NO_FREE;
            end else begin
               cur_in  = cur_ff + 1'b1;
               rd_en   = 1'b1;
               rd_addr = cur_in;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.granted_page      = granted_ff;
         rsp_data_in.status            = status_ff;
         rsp_data_in.free_total        = free_count_ff;
         rsp_data_in.kernel_free_total = kfree_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         free_count_ff <= '0;
         kfree_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_count_ff <= free_count_in;
         kfree_ff      <= kfree_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      page_word_ff <= page_word_in;
      page_bit_ff  <= page_bit_in;
      kern_page_ff <= kern_page_in;
      cur_ff       <= cur_in;
      granted_ff   <= granted_in;
      status_ff    <= status_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // A successful allocation takes exactly one page off the free count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && hit |=> free_count_ff == $past(free_count_ff) - 1'b1)
      else $error("free count not lowered by one on allocation");

   // The counters never pass their limits.
   assert property (@(posedge clock) disable iff (reset)
      (free_count_ff <= FREE_LIMIT) && (kfree_ff <= KFREE_LIMIT))
      else $error("free counter beyond its limit");

   // The search stays inside its pool.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cur_ff >= lo_word) && (cur_ff <= hi_word))
      else $error("bitmap search left its pool");

   // The bitmap is written only by the clearing pass and by an update.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR) || (state_ff == ST_RMW) || (state_ff == ST_SCAN))
      else $error("bitmap written outside an update");

   // A failed allocation never grants a page.
   assert property (@(posedge clock) disable iff (reset)
      load_rsp && (status_ff == STATUS_NO_FREE) |=> rsp_data_ff.granted_page == '0)
      else $error("failed allocation carries a page");

endmodule
